FILE: rtl/braille_pager_display_defines.svh
// assertion macros for the braille pager rtl
`ifndef BRAILLE_PAGER_DISPLAY_DEFINES_SVH
`define BRAILLE_PAGER_DISPLAY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpd_pkg.sv
// types, constants and glyph table for the braille pager
`default_nettype none

package bpd_pkg;

  localparam int HISTORY_DEPTH_DEF = 512;
  localparam int QUEUE_DEPTH       = 2;
  localparam int PAGE_CELLS        = 5;
  localparam int CELL_W            = 6;
  localparam int LEDS_W            = PAGE_CELLS * CELL_W;
  localparam int BYTE_W            = 8;
  localparam int TIMEOUT_W         = 16;
  localparam int ELAPSED_W         = 17;
  localparam int LETTERS           = 26;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5a;

  typedef enum logic [1:0] {
    K_BYTE,
    K_BUTTON,
    K_TICK,
    K_NONE
  } kind_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_MOVED = 2'd1,
    BTN_EMPTY = 2'd2,
    BTN_LIMIT = 2'd3
  } btn_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BACK,
    ST_PAGE,
    ST_LOAD,
    ST_RESC
  } state_t;

  // classified command as it sits in the queue
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] rx_byte;
    logic              fwd_press;
    logic              back_press;
    logic              resc_press;
  } cmd_t;

  localparam logic [CELL_W-1:0] CELL_PATTERNS [LETTERS] = '{
    6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0b, 6'h1b, 6'h13, 6'h0a, 6'h1a,
    6'h05, 6'h07, 6'h0d, 6'h1d, 6'h15, 6'h0f, 6'h1f, 6'h17, 6'h0e, 6'h1e,
    6'h25, 6'h27, 6'h3a, 6'h2d, 6'h3d, 6'h35
  };

  function automatic logic [CELL_W-1:0] cell_bits(input logic [BYTE_W-1:0] ch);
    logic [BYTE_W-1:0] idx;
    logic [CELL_W-1:0] bits;
    idx  = '0;
    bits = '0;
    if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
      idx  = ch - ASCII_LOWER_A;
      bits = CELL_PATTERNS[idx[4:0]];
    end else if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
      idx  = ch - ASCII_UPPER_A;
      bits = CELL_PATTERNS[idx[4:0]];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bpd_if.sv
// request and response channel interfaces of the braille pager
`default_nettype none

interface bpd_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [bpd_pkg::BYTE_W-1:0] rx_byte;
  logic                       fwd_level;
  logic                       back_level;
  logic                       rescan_level;

  modport source (
    output valid, req_type, rx_byte, fwd_level, back_level, rescan_level,
    input  ready
  );
  modport sink (
    input  valid, req_type, rx_byte, fwd_level, back_level, rescan_level,
    output ready
  );
endinterface

interface bpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpd_pkg::LEDS_W-1:0] leds;
  logic [1:0]                 fwd_status;
  logic [1:0]                 back_status;
  logic                       rescan_request;
  logic                       rescan_pending;
  logic                       rescan_timed_out;
  logic                       byte_dropped;

  modport source (
    output valid, leds, fwd_status, back_status, rescan_request, rescan_pending,
           rescan_timed_out, byte_dropped,
    input  ready
  );
  modport sink (
    input  valid, leds, fwd_status, back_status, rescan_request, rescan_pending,
           rescan_timed_out, byte_dropped,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/bpd_front.sv
// front end: takes request beats, edge-detects buttons, builds commands
`default_nettype none

module bpd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  bpd_in_if.sink             req,
  output bpd_pkg::cmd_t      push_data,
  output logic               push,
  input  wire logic          push_ready
);

  // bit 0 fwd, bit 1 back, bit 2 rescan; 1 is released
  logic [2:0] last_levels;

  assign req.ready = push_ready;
  assign push      = req.valid && push_ready;

  always_comb begin
    push_data            = '0;
    push_data.rx_byte    = req.rx_byte;
    case (req.req_type)
      bpd_pkg::REQ_BYTE:   push_data.kind = bpd_pkg::K_BYTE;
      bpd_pkg::REQ_BUTTON: push_data.kind = bpd_pkg::K_BUTTON;
      bpd_pkg::REQ_TICK:   push_data.kind = bpd_pkg::K_TICK;
      default:             push_data.kind = bpd_pkg::K_NONE;
    endcase
    // falling level is a press
    push_data.fwd_press  = last_levels[0] && !req.fwd_level;
    push_data.back_press = last_levels[1] && !req.back_level;
    push_data.resc_press = last_levels[2] && !req.rescan_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels <= 3'b111;
    end else if (push && req.req_type == bpd_pkg::REQ_BUTTON) begin
      last_levels <= {req.rescan_level, req.back_level, req.fwd_level};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpd_queue.sv
// short command queue between front and back
`default_nettype none

module bpd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bpd_pkg::cmd_t  push_data,
  output logic                push_ready,
  input  wire logic           pop,
  output bpd_pkg::cmd_t       pop_data,
  output logic                pop_valid
);

  localparam int PTR_W = (bpd_pkg::QUEUE_DEPTH > 1) ? $clog2(bpd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bpd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bpd_pkg::QUEUE_DEPTH - 1);

  bpd_pkg::cmd_t    entries [bpd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign push_ready = fill != CNT_W'(bpd_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpd_back.sv
// back end: history memory, paging, rescan timer and result register
`default_nettype none

module bpd_back #(
  parameter int HISTORY_DEPTH = bpd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpd_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  input  wire logic                          cmd_valid,
  input  wire bpd_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  bpd_out_if.source                          rsp
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = $clog2(HISTORY_DEPTH + bpd_pkg::PAGE_CELLS) + 1;
  localparam int LW = bpd_pkg::LEDS_W;
  localparam int EW = bpd_pkg::ELAPSED_W;
  localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};
  localparam logic [2:0]    LAST_CELL   = 3'(bpd_pkg::PAGE_CELLS);

  bpd_pkg::state_t state, state_next, ret_state;
  bpd_pkg::cmd_t   cur;

  logic [bpd_pkg::BYTE_W-1:0] mem [HISTORY_DEPTH];
  logic [bpd_pkg::BYTE_W-1:0] rd_data;

  logic [CW-1:0]                  hist_count;
  logic signed [PW-1:0]           page_pos;
  logic [LW-1:0]                  leds;
  logic                           waiting;
  logic [EW-1:0]                  elapsed;
  logic [bpd_pkg::TIMEOUT_W-1:0]  timeout;
  bpd_pkg::btn_status_t           fwd_st;
  bpd_pkg::btn_status_t           back_st;
  logic [2:0]                     rd_idx;
  logic                           rd_vld;
  logic [2:0]                     rd_cell;
  logic                           rd_hit;
  logic [LW-1:0]                  page_acc;
  logic [LW-1:0]                  page_merge;

  logic                           out_valid;
  logic [LW-1:0]                  out_leds;
  bpd_pkg::btn_status_t           out_fwd;
  bpd_pkg::btn_status_t           out_back;
  logic                           out_req;
  logic                           out_pending;
  logic                           out_timed_out;
  logic                           out_dropped;

  logic                 out_free;
  logic                 emit;
  logic                 mem_we;
  logic                 hist_full;
  logic signed [PW-1:0] count_s;
  logic signed [PW-1:0] pos_plus;
  logic signed [PW-1:0] pos_minus;
  logic                 fwd_move;
  logic                 back_move;
  bpd_pkg::btn_status_t fwd_code;
  bpd_pkg::btn_status_t back_code;
  logic [PW-1:0]        rd_at;
  logic                 rd_hit_now;
  logic [EW-1:0]        elapsed_sat;
  logic                 expire;

  assign out_free  = !out_valid || rsp.ready;
  assign hist_full = hist_count == CW'(HISTORY_DEPTH);
  assign count_s   = $signed({{(PW-CW){1'b0}}, hist_count});
  assign pos_plus  = page_pos + PW'(bpd_pkg::PAGE_CELLS);
  assign pos_minus = page_pos - PW'(bpd_pkg::PAGE_CELLS);
  assign fwd_move  = (hist_count != '0) && (pos_plus < count_s);
  assign back_move = (hist_count != '0) && !pos_minus[PW-1];

  assign fwd_code  = !cur.fwd_press      ? bpd_pkg::BTN_NONE  :
                     (hist_count == '0)  ? bpd_pkg::BTN_EMPTY :
                     fwd_move            ? bpd_pkg::BTN_MOVED : bpd_pkg::BTN_LIMIT;
  assign back_code = !cur.back_press     ? bpd_pkg::BTN_NONE  :
                     (hist_count == '0)  ? bpd_pkg::BTN_EMPTY :
                     back_move           ? bpd_pkg::BTN_MOVED : bpd_pkg::BTN_LIMIT;

  // page start is never negative while reading
  assign rd_at      = page_pos + PW'(rd_idx);
  assign rd_hit_now = rd_at < {{(PW-CW){1'b0}}, hist_count};

  assign elapsed_sat = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + EW'(1);
  assign expire      = elapsed_sat > {{(EW-bpd_pkg::TIMEOUT_W){1'b0}}, timeout};

  always_comb begin
    page_merge = page_acc;
    if (rd_vld && rd_hit) begin
      for (int c = 0; c < bpd_pkg::PAGE_CELLS; c++) begin
        if (rd_cell == 3'(c)) begin
          page_merge[c*bpd_pkg::CELL_W +: bpd_pkg::CELL_W] = bpd_pkg::cell_bits(rd_data);
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bpd_pkg::ST_IDLE: begin
        if (cmd_valid && out_free && cmd.kind == bpd_pkg::K_BUTTON) begin
          state_next = bpd_pkg::ST_FWD;
        end
      end
      bpd_pkg::ST_FWD: begin
        state_next = (cur.fwd_press && fwd_move) ? bpd_pkg::ST_PAGE : bpd_pkg::ST_BACK;
      end
      bpd_pkg::ST_BACK: begin
        state_next = (cur.back_press && back_move) ? bpd_pkg::ST_PAGE : bpd_pkg::ST_RESC;
      end
      bpd_pkg::ST_PAGE: begin
        if (rd_idx == LAST_CELL) begin
          state_next = bpd_pkg::ST_LOAD;
        end
      end
      bpd_pkg::ST_LOAD: state_next = ret_state;
      bpd_pkg::ST_RESC: state_next = bpd_pkg::ST_IDLE;
      default:          state_next = bpd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop = 1'b0;
    emit    = 1'b0;
    mem_we  = 1'b0;
    case (state)
      bpd_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid && out_free;
        emit    = cmd_pop && cmd.kind != bpd_pkg::K_BUTTON;
        mem_we  = cmd_pop && cmd.kind == bpd_pkg::K_BYTE && !hist_full;
      end
      bpd_pkg::ST_RESC: emit = 1'b1;
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // history memory with one write and one read port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[hist_count[AW-1:0]] <= cmd.rx_byte;
    end
    rd_data <= mem[rd_at[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpd_pkg::ST_IDLE;
      hist_count <= '0;
      page_pos   <= '0 - PW'(bpd_pkg::PAGE_CELLS);
      leds       <= '0;
      waiting    <= 1'b0;
      elapsed    <= '0;
      timeout    <= bpd_pkg::TIMEOUT_RESET;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= (state == bpd_pkg::ST_PAGE) && (rd_idx != LAST_CELL);
      rd_cell <= rd_idx;
      rd_hit  <= rd_hit_now;
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (rd_vld) begin
        page_acc <= page_merge;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        bpd_pkg::ST_IDLE: begin
          if (cmd_pop) begin
            cur           <= cmd;
            out_leds      <= leds;
            out_fwd       <= bpd_pkg::BTN_NONE;
            out_back      <= bpd_pkg::BTN_NONE;
            out_req       <= 1'b0;
            out_pending   <= waiting;
            out_timed_out <= 1'b0;
            out_dropped   <= 1'b0;
            case (cmd.kind)
              bpd_pkg::K_BYTE: begin
                // any byte ends a rescan wait, even a dropped one
                waiting     <= 1'b0;
                out_pending <= 1'b0;
                out_dropped <= hist_full;
                if (!hist_full) begin
                  hist_count <= hist_count + CW'(1);
                end
              end
              bpd_pkg::K_TICK: begin
                if (waiting) begin
                  elapsed       <= elapsed_sat;
                  waiting       <= !expire;
                  out_pending   <= !expire;
                  out_timed_out <= expire;
                end
              end
              default: begin
                out_dropped <= 1'b0;
              end
            endcase
          end
        end
        bpd_pkg::ST_FWD: begin
          fwd_st    <= fwd_code;
          ret_state <= bpd_pkg::ST_BACK;
          rd_idx    <= '0;
          page_acc  <= '0;
          if (cur.fwd_press && fwd_move) begin
            page_pos <= pos_plus;
          end
        end
        bpd_pkg::ST_BACK: begin
          back_st   <= back_code;
          ret_state <= bpd_pkg::ST_RESC;
          rd_idx    <= '0;
          page_acc  <= '0;
          if (cur.back_press && back_move) begin
            page_pos <= pos_minus;
          end
        end
        bpd_pkg::ST_PAGE: begin
          if (rd_idx != LAST_CELL) begin
            rd_idx <= rd_idx + 3'd1;
          end
        end
        bpd_pkg::ST_LOAD: begin
          leds <= page_merge;
        end
        bpd_pkg::ST_RESC: begin
          out_fwd       <= fwd_st;
          out_back      <= back_st;
          out_req       <= cur.resc_press;
          out_timed_out <= 1'b0;
          out_dropped   <= 1'b0;
          if (cur.resc_press) begin
            hist_count  <= '0;
            page_pos    <= '0 - PW'(bpd_pkg::PAGE_CELLS);
            leds        <= '0;
            elapsed     <= '0;
            waiting     <= 1'b1;
            out_leds    <= '0;
            out_pending <= 1'b1;
          end else begin
            out_leds    <= leds;
            out_pending <= waiting;
          end
        end
        default: begin
          rd_idx <= '0;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.leds             = out_leds;
  assign rsp.fwd_status       = out_fwd;
  assign rsp.back_status      = out_back;
  assign rsp.rescan_request   = out_req;
  assign rsp.rescan_pending   = out_pending;
  assign rsp.rescan_timed_out = out_timed_out;
  assign rsp.byte_dropped     = out_dropped;

endmodule

`default_nettype wire

FILE: rtl/braille_pager_display.sv
// five-cell braille pager: bytes, tick and buttons in, one result beat per request beat
// path: byte, tick and unused beats pass the queue, then the result register; a button
// beat passes the queue and back end states FWD, BACK and RESC, with PAGE and LOAD for
// each page move (two at most), PAGE reading one history entry per cycle
// throughput: a beat per cycle for bytes and ticks with rsp ready, none during a button
// reset (synchronous, active high) empties history and queue, blanks leds, pointer to -5
`default_nettype none

`include "braille_pager_display_defines.svh"

module braille_pager_display #(
  parameter int HISTORY_DEPTH = bpd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpd_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  bpd_in_if.sink                             req,
  bpd_out_if.source                          rsp
);

  bpd_pkg::cmd_t push_data;
  bpd_pkg::cmd_t pop_data;
  logic          q_push;
  logic          q_ready;
  logic          q_valid;
  logic          q_pop;

  bpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_data  (push_data),
    .push       (q_push),
    .push_ready (q_ready)
  );

  bpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (pop_data),
    .pop_valid  (q_valid)
  );

  bpd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_valid),
    .cmd         (pop_data),
    .cmd_pop     (q_pop),
    .rsp         (rsp)
  );

  `BPD_ASSERT_NXT(a_push_lands, clk, rst, q_push, q_valid, "queue empty after push")
  `BPD_ASSERT_NXT(a_queue_holds, clk, rst, q_valid && !q_pop, q_valid, "queued command lost")
  `BPD_ASSERT_IMP(a_timeout_ends_wait, clk, rst, rsp.valid && rsp.rescan_timed_out, !rsp.rescan_pending && !rsp.rescan_request, "timeout beat still pending")

endmodule

`default_nettype wire
